// ===== src/agau_pkg.sv =====
// Package for the affine global alignment unit: shared types and constants.
// No dependencies.
`timescale 1ns / 1ps
package agau_pkg;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_LEN_A      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEN_B      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_OPEN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_EXTEND = 2'd3;

    localparam logic [1:0] OP_PAIR  = 2'd0;
    localparam logic [1:0] OP_GAP_A = 2'd1;
    localparam logic [1:0] OP_GAP_B = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    localparam logic [1:0] LVL_MAIN = 2'd0;
    localparam logic [1:0] LVL_VGAP = 2'd1;
    localparam logic [1:0] LVL_HGAP = 2'd2;

    localparam logic signed [31:0] SENTINEL_FX = -32'sd2560000;

    typedef struct packed {
        logic               action;
        logic signed [31:0] match;
        logic signed [31:0] fp_bonus;
        logic signed [31:0] fn_bonus;
    } in_item_t;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] pos_a;
        logic [7:0] pos_b;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [30:0]          data;
    } cfg_item_t;
endpackage

// ===== src/agau_if.sv =====
// Valid/ready channel interface with a generic payload type.
// No dependencies.
`timescale 1ns / 1ps
interface agau_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== src/affine_global_alignment_unit.sv =====
// Top level of the affine global alignment unit: fill sequencer, row buffers,
// trace memories and traceback. Depends on agau_pkg and agau_if.
`timescale 1ns / 1ps
// Load transactions (action 0) each fill one cell of the main, vertical-gap and
// horizontal-gap matrices in row-major order; after the last cell each fetch
// transaction (action 1) returns one traceback step, end first. A load passes,
// between one accepted transaction and the next, through the accepting cycle,
// a registered row-buffer read, then one shared saturating adder forming the
// diagonal sum and the four gap candidates in turn, and the selection.
// A fetch returns its step after a trace memory read and then a decide state;
// a fetch outside the traceback phase returns an OP_NONE item at once.
// Results wait in an output register; a new transaction is accepted only
// after the previous one has finished and its result, if any, is taken, so
// the input also stalls while the output is held off.
// Row buffers and trace marks need no clearing pass after reset.
module affine_global_alignment_unit #(
    parameter int MAX_LEN = 256,
    parameter int SCORE_W = 32
) (
    input  logic clk,
    input  logic rst_n,
    agau_if.sink   in_ch,
    agau_if.source out_ch,
    agau_if.sink   cfg
);
    import agau_pkg::*;

    localparam int LW  = $clog2(MAX_LEN + 1);
    localparam int CW  = $clog2(MAX_LEN);
    localparam int TAW = 2 * CW;
    localparam int XW  = SCORE_W + 36;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_VO, S_VE, S_HO, S_HE, S_D, S_SEL, S_TRD, S_TDEC, S_OUT
    } state_t;
    typedef enum logic [1:0] { PH_FILL, PH_TRACE, PH_DONE } phase_t;

    state_t state_reg;
    phase_t phase_reg;
    logic [8:0]  len_a_reg, len_b_reg;
    logic [30:0] gap_open_reg, gap_ext_reg;
    logic [LW-1:0] row_reg, col_reg, eff_a, eff_b;
    logic [1:0] level_reg;
    logic signed [SCORE_W-1:0] left_m_reg, left_h_reg, diag_reg;
    logic signed [SCORE_W-1:0] up_m_reg, up_v_reg, vo_reg, ho_reg, mx_reg, my_reg, d_reg;
    logic vtr_reg, htr_reg;
    logic signed [31:0] mt_reg, fp_reg, fn_reg;
    out_item_t out_reg;
    logic out_valid_reg;

    logic signed [SCORE_W-1:0] pm_mem [MAX_LEN+1];
    logic signed [SCORE_W-1:0] pv_mem [MAX_LEN+1];
    logic [1:0] tm_mem [MAX_LEN*MAX_LEN];
    logic       tv_mem [MAX_LEN*MAX_LEN];
    logic       th_mem [MAX_LEN*MAX_LEN];
    logic signed [SCORE_W-1:0] pm_q, pv_q;
    logic [1:0] tm_q;
    logic tv_q, th_q;

    function automatic logic [LW-1:0] eff_len(input logic [8:0] n);
        logic [LW:0] w;
        w = (LW + 1)'(n);
        if (n == 9'd0) return LW'(1);
        if (w > (LW + 1)'(MAX_LEN)) return LW'(MAX_LEN);
        return w[LW-1:0];
    endfunction

    function automatic logic signed [SCORE_W-1:0] sat(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] hi, lo;
        hi = XW'((64'sd1 <<< (SCORE_W - 1)) - 64'sd1);
        lo = -hi - XW'(1);
        if (v > hi) return hi[SCORE_W-1:0];
        if (v < lo) return lo[SCORE_W-1:0];
        return v[SCORE_W-1:0];
    endfunction

    assign eff_a = eff_len(len_a_reg);
    assign eff_b = eff_len(len_b_reg);

    // Shared adder: three signed operands, saturated.
    logic signed [XW-1:0] op_a, op_b, op_c;
    logic signed [SCORE_W-1:0] sum;
    logic signed [XW-1:0] bnd_k;
    logic [LW-1:0] bnd_n;
    always_comb
    begin
        op_a = '0; op_b = '0; op_c = '0; bnd_n = col_reg;
        case (state_reg)
            S_RD:
            begin
                bnd_n = (row_reg == LW'(1)) ? col_reg : row_reg;
            end
            S_VO:
            begin
                op_a = XW'(diag_reg);
                op_b = XW'(mt_reg);
                op_c = XW'(fp_reg);
            end
            S_VE:
            begin
                op_a = XW'(up_m_reg);
                op_b = -XW'(signed'({1'b0, gap_open_reg})) - XW'(signed'({1'b0, gap_ext_reg}));
                op_c = XW'(fn_reg);
            end
            S_HO:
            begin
                op_a = XW'(up_v_reg);
                op_b = -XW'(signed'({1'b0, gap_ext_reg}));
                op_c = XW'(fn_reg);
            end
            S_HE:
            begin
                op_a = XW'(left_m_reg);
                op_b = -XW'(signed'({1'b0, gap_open_reg})) - XW'(signed'({1'b0, gap_ext_reg}));
                op_c = XW'(fn_reg);
            end
            S_D:
            begin
                op_a = XW'(left_h_reg);
                op_b = -XW'(signed'({1'b0, gap_ext_reg}));
                op_c = XW'(fn_reg);
            end
            default:
            begin
                bnd_n = col_reg;
            end
        endcase
    end
    assign sum = sat(op_a + op_b + op_c);
    // Boundary value -(open + ext*k): one 31x(LW) multiply.
    assign bnd_k = -(XW'(signed'({1'b0, gap_open_reg}))
                   + XW'(signed'({1'b0, gap_ext_reg})) * XW'(signed'({1'b0, bnd_n})));

    logic signed [XW-1:0] bnd_rm1;
    assign bnd_rm1 = -(XW'(signed'({1'b0, gap_open_reg}))
                   + XW'(signed'({1'b0, gap_ext_reg})) * XW'(signed'({1'b0, row_reg - LW'(1)})));

    logic [TAW-1:0] taddr;
    logic [2*LW-1:0] tlin;
    assign tlin = (2*LW)'(row_reg - LW'(1)) * (2*LW)'(MAX_LEN) + (2*LW)'(col_reg - LW'(1));
    assign taddr = tlin[TAW-1:0];

    logic signed [SCORE_W-1:0] sentinel;
    assign sentinel = sat(XW'(SENTINEL_FX));

    logic signed [SCORE_W-1:0] m_val;
    logic [1:0] m_code;
    always_comb
    begin
        if (d_reg >= mx_reg && d_reg >= my_reg)
        begin
            m_val = d_reg; m_code = LVL_MAIN;
        end
        else if (mx_reg > my_reg)
        begin
            m_val = mx_reg; m_code = LVL_VGAP;
        end
        else
        begin
            m_val = my_reg; m_code = LVL_HGAP;
        end
    end

    // Memories.
    always_ff @(posedge clk)
    begin
        pm_q <= pm_mem[col_reg];
        pv_q <= pv_mem[col_reg];
        tm_q <= tm_mem[taddr];
        tv_q <= tv_mem[taddr];
        th_q <= th_mem[taddr];
        if (state_reg == S_SEL)
        begin
            pm_mem[col_reg] <= m_val;
            pv_mem[col_reg] <= mx_reg;
            tm_mem[taddr]   <= m_code;
            tv_mem[taddr]   <= vtr_reg;
            th_mem[taddr]   <= htr_reg;
        end
    end

    // Traceback decision.
    logic [1:0] t_op, t_lvl;
    logic [1:0] lvl0;
    always_comb
    begin
        t_lvl = level_reg;
        t_op  = OP_PAIR;
        lvl0  = level_reg;
        if (row_reg == '0)
        begin
            t_op = OP_GAP_B; t_lvl = LVL_HGAP;
        end
        else if (col_reg == '0)
        begin
            t_op = OP_GAP_A; t_lvl = LVL_VGAP;
        end
        else
        begin
            if (level_reg == LVL_MAIN)
            begin
                lvl0 = (tm_q == LVL_MAIN) ? LVL_MAIN : ((tm_q == LVL_VGAP) ? LVL_VGAP : LVL_HGAP);
            end
            t_lvl = lvl0;
            if (lvl0 == LVL_MAIN)
            begin
                t_op = OP_PAIR;
            end
            else if (lvl0 == LVL_VGAP)
            begin
                t_op = OP_GAP_A;
                if (tv_q) t_lvl = LVL_MAIN;
            end
            else
            begin
                t_op = OP_GAP_B;
                if (th_q) t_lvl = LVL_MAIN;
            end
        end
    end

    logic [LW-1:0] rm1, cm1;
    assign rm1 = row_reg - LW'(1);
    assign cm1 = col_reg - LW'(1);

    logic t_last;
    assign t_last = ((t_op == OP_GAP_B) ? row_reg == '0 : rm1 == '0) &&
                    ((t_op == OP_GAP_A) ? col_reg == '0 : cm1 == '0);

    assign in_ch.ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign cfg.ready    = 1'b1;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.payload = out_reg;

    logic in_fire;
    assign in_fire = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_FILL;
            len_a_reg     <= 9'd1;
            len_b_reg     <= 9'd1;
            gap_open_reg  <= '0;
            gap_ext_reg   <= '0;
            row_reg       <= LW'(1);
            col_reg       <= LW'(1);
            level_reg     <= LVL_MAIN;
            left_m_reg    <= '0;
            left_h_reg    <= '0;
            diag_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.payload.index)
                    REG_LEN_A:      len_a_reg    <= cfg.payload.data[8:0];
                    REG_LEN_B:      len_b_reg    <= cfg.payload.data[8:0];
                    REG_GAP_OPEN:   gap_open_reg <= cfg.payload.data;
                    REG_GAP_EXTEND: gap_ext_reg  <= cfg.payload.data;
                    default:        gap_ext_reg  <= gap_ext_reg;
                endcase
            end
            if (out_valid_reg && out_ch.ready) out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        mt_reg <= in_ch.payload.match;
                        fp_reg <= in_ch.payload.fp_bonus;
                        fn_reg <= in_ch.payload.fn_bonus;
                        if (in_ch.payload.action)
                        begin
                            if (phase_reg == PH_TRACE)
                            begin
                                state_reg <= S_TRD;
                            end
                            else
                            begin
                                out_reg       <= '{op: OP_NONE, pos_a: '0, pos_b: '0, last: 1'b0};
                                out_valid_reg <= 1'b1;
                            end
                        end
                        else if (phase_reg == PH_FILL)
                        begin
                            if (col_reg > eff_a)
                            begin
                                if (row_reg + LW'(1) > eff_b)
                                begin
                                    row_reg <= eff_b; col_reg <= eff_a;
                                    level_reg <= LVL_MAIN; phase_reg <= PH_TRACE;
                                end
                                else
                                begin
                                    col_reg   <= LW'(1);
                                    row_reg   <= row_reg + LW'(1);
                                    state_reg <= S_RD;
                                end
                            end
                            else if (row_reg > eff_b)
                            begin
                                row_reg <= eff_b; col_reg <= eff_a;
                                level_reg <= LVL_MAIN; phase_reg <= PH_TRACE;
                            end
                            else
                            begin
                                state_reg <= S_RD;
                            end
                        end
                    end
                end
                S_RD:
                begin
                    // Memory read data valid next cycle; fix up boundaries.
                    if (col_reg == LW'(1))
                    begin
                        left_m_reg <= sat(bnd_k);
                        left_h_reg <= sentinel;
                        diag_reg   <= (row_reg == LW'(1)) ? '0 : sat(bnd_rm1);
                    end
                    state_reg <= S_VO;
                end
                S_VO:
                begin
                    up_m_reg  <= (row_reg == LW'(1)) ? sat(bnd_k) : pm_q;
                    up_v_reg  <= (row_reg == LW'(1)) ? sentinel : pv_q;
                    d_reg     <= sum;
                    state_reg <= S_VE;
                end
                S_VE:
                begin
                    vo_reg    <= sum;
                    state_reg <= S_HO;
                end
                S_HO:
                begin
                    vtr_reg <= (vo_reg >= sum);
                    mx_reg  <= (vo_reg >= sum) ? vo_reg : sum;
                    state_reg <= S_HE;
                end
                S_HE:
                begin
                    ho_reg    <= sum;
                    state_reg <= S_D;
                end
                S_D:
                begin
                    htr_reg <= (ho_reg >= sum);
                    my_reg  <= (ho_reg >= sum) ? ho_reg : sum;
                    state_reg <= S_SEL;
                end
                S_SEL:
                begin
                    diag_reg   <= up_m_reg;
                    left_m_reg <= m_val;
                    left_h_reg <= my_reg;
                    if (col_reg + LW'(1) > eff_a)
                    begin
                        if (row_reg + LW'(1) > eff_b)
                        begin
                            row_reg <= eff_b; col_reg <= eff_a;
                            level_reg <= LVL_MAIN; phase_reg <= PH_TRACE;
                        end
                        else
                        begin
                            col_reg <= LW'(1);
                            row_reg <= row_reg + LW'(1);
                        end
                    end
                    else
                    begin
                        col_reg <= col_reg + LW'(1);
                    end
                    state_reg <= S_IDLE;
                end
                S_TRD:
                begin
                    state_reg <= S_TDEC;
                end
                S_TDEC:
                begin
                    level_reg <= t_lvl;
                    out_reg.op <= t_op;
                    out_reg.pos_a <= (t_op == OP_GAP_A) ? 8'd0 : 8'(cm1);
                    out_reg.pos_b <= (t_op == OP_GAP_B) ? 8'd0 : 8'(rm1);
                    if (t_op != OP_GAP_A) col_reg <= cm1;
                    if (t_op != OP_GAP_B) row_reg <= rm1;
                    out_reg.last <= t_last;
                    if (t_last)
                        phase_reg <= PH_DONE;
                    out_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule
